// ===== design/chf_pkg.sv =====
// ----------------------------------------------------------------------------
// chf_pkg: shared definitions for the chunk header framer
// Constants, command codes and the byte-burst entry that links front and back.
// ----------------------------------------------------------------------------
package chf_pkg;

    localparam int CMD_W         = 1;
    localparam int CSID_W        = 17;
    localparam int FMT_W         = 2;
    localparam int TS_W          = 32;
    localparam int MLEN_W        = 24;
    localparam int MTYPE_W       = 8;
    localparam int SID_W         = 32;
    localparam int PCOUNT_W      = 24;
    localparam int BYTE_W        = 8;
    localparam int CHUNK_LIMIT_W = 17;

    localparam logic [CMD_W-1:0] CMD_HEADER  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_PAYLOAD = 1'b1;

    localparam logic [CHUNK_LIMIT_W-1:0] CHUNK_LIMIT_RESET = 17'd128;
    localparam logic [TS_W-1:0]          TS_SAT            = 32'h00FF_FFFF;
    localparam logic [CSID_W-1:0]        ONE_BYTE_LIMIT    = 17'd64;
    localparam logic [CSID_W-1:0]        TWO_BYTE_LIMIT    = 17'd320;

    // Longest burst: 3 basic header bytes, 11 message header bytes, 4 extended.
    localparam int MAX_BYTES  = 18;
    localparam int LEN_W      = $clog2(MAX_BYTES + 1);
    localparam int IDX_W      = $clog2(MAX_BYTES);
    localparam int MH_BYTES   = 15;
    localparam int MH_BASE    = 11;
    localparam int EXT_BYTES  = 4;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // One queued burst: bytes go out from element 0 upward; the last one
    // carries end_flag as its chunk_end.
    typedef struct packed {
        logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [LEN_W-1:0]                 len;
        logic                             end_flag;
    } burst_t;

endpackage

// ===== design/chf_queue.sv =====
// ----------------------------------------------------------------------------
// chf_queue: burst queue between front and back
// A small register FIFO holding pre-built byte bursts.
// ----------------------------------------------------------------------------
module chf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  chf_pkg::burst_t wr_burst,
    input  logic            rd_en,
    output chf_pkg::burst_t rd_burst,
    output logic            q_full,
    output logic            q_empty
);

    chf_pkg::burst_t                  slot_reg [chf_pkg::Q_DEPTH];
    logic [chf_pkg::Q_PTR_W-1:0]      wr_ptr_reg;
    logic [chf_pkg::Q_PTR_W-1:0]      rd_ptr_reg;
    logic [chf_pkg::Q_CNT_W-1:0]      count_reg;
    logic                             do_wr;
    logic                             do_rd;

    assign q_full   = (count_reg == chf_pkg::Q_CNT_W'(chf_pkg::Q_DEPTH));
    assign q_empty  = (count_reg == '0);
    assign do_wr    = wr_en && !q_full;
    assign do_rd    = rd_en && !q_empty;
    assign rd_burst = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + chf_pkg::Q_PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + chf_pkg::Q_PTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + chf_pkg::Q_CNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - chf_pkg::Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_burst;
        end
    end

endmodule

// ===== design/chf_front.sv =====
// ----------------------------------------------------------------------------
// chf_front: item intake and classification
// Builds a header burst or a single payload byte and tracks the chunk budget.
// ----------------------------------------------------------------------------
module chf_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [chf_pkg::CHUNK_LIMIT_W-1:0]    cfg_data,
    input  logic                                 push,
    output logic                                 full,
    input  logic [chf_pkg::CMD_W-1:0]            cmd,
    input  logic [chf_pkg::CSID_W-1:0]           chunk_stream,
    input  logic [chf_pkg::FMT_W-1:0]            header_format,
    input  logic [chf_pkg::TS_W-1:0]             time_stamp,
    input  logic [chf_pkg::MLEN_W-1:0]           message_length,
    input  logic [chf_pkg::MTYPE_W-1:0]          message_type,
    input  logic [chf_pkg::SID_W-1:0]            stream_ident,
    input  logic [chf_pkg::PCOUNT_W-1:0]         payload_count,
    input  logic [chf_pkg::BYTE_W-1:0]           data_byte,
    input  logic                                 q_full,
    output logic                                 q_wr,
    output chf_pkg::burst_t                      q_burst
);

    typedef enum logic [1:0] {
        BH_ONE,
        BH_TWO,
        BH_THREE
    } bh_kind_t;

    logic [chf_pkg::CHUNK_LIMIT_W-1:0]          chunk_limit_reg;
    logic [chf_pkg::CHUNK_LIMIT_W-1:0]          payload_left_reg;
    logic [chf_pkg::CHUNK_LIMIT_W-1:0]          payload_left_next;
    logic [chf_pkg::CHUNK_LIMIT_W-1:0]          take;
    logic                                       accept;
    logic                                       ext_ts;
    logic [23:0]                                ts24;
    logic [chf_pkg::CSID_W-1:0]                 csid_off;
    bh_kind_t                                   bh_kind;
    logic [chf_pkg::MH_BYTES-1:0][7:0]          mh;
    logic [chf_pkg::MAX_BYTES-1:0][7:0]         hdr_bytes;
    logic [chf_pkg::LEN_W-1:0]                  bh_len;
    logic [chf_pkg::LEN_W-1:0]                  hdr_len;

    assign cfg_ready = 1'b1;
    assign full      = q_full;
    assign accept    = push && !q_full;

    always_comb
    begin
        ext_ts   = (time_stamp >= chf_pkg::TS_SAT);
        ts24     = ext_ts ? 24'hFF_FFFF : time_stamp[23:0];
        csid_off = chunk_stream - chf_pkg::ONE_BYTE_LIMIT;

        if (chunk_stream < chf_pkg::ONE_BYTE_LIMIT)
        begin
            bh_kind = BH_ONE;
        end
        else if (chunk_stream < chf_pkg::TWO_BYTE_LIMIT)
        begin
            bh_kind = BH_TWO;
        end
        else
        begin
            bh_kind = BH_THREE;
        end

        // Message header and extended timestamp, first byte in element 0.
        mh = {time_stamp[7:0], time_stamp[15:8], time_stamp[23:16], time_stamp[31:24],
              stream_ident[31:24], stream_ident[23:16], stream_ident[15:8],
              stream_ident[7:0], message_type,
              message_length[7:0], message_length[15:8], message_length[23:16],
              ts24[7:0], ts24[15:8], ts24[23:16]};

        unique case (bh_kind)
            BH_ONE:
            begin
                hdr_bytes = {16'h0, mh, header_format, chunk_stream[5:0]};
                bh_len    = chf_pkg::LEN_W'(1);
            end
            BH_TWO:
            begin
                hdr_bytes = {8'h0, mh, csid_off[7:0], header_format, 6'd0};
                bh_len    = chf_pkg::LEN_W'(2);
            end
            BH_THREE:
            begin
                hdr_bytes = {mh, csid_off[15:8], csid_off[7:0], header_format, 6'd1};
                bh_len    = chf_pkg::LEN_W'(3);
            end
            default:
            begin
                hdr_bytes = '0;
                bh_len    = chf_pkg::LEN_W'(1);
            end
        endcase

        hdr_len = bh_len + chf_pkg::LEN_W'(chf_pkg::MH_BASE)
                + (ext_ts ? chf_pkg::LEN_W'(chf_pkg::EXT_BYTES) : '0);

        if (payload_count < chf_pkg::PCOUNT_W'(chunk_limit_reg))
        begin
            take = payload_count[chf_pkg::CHUNK_LIMIT_W-1:0];
        end
        else
        begin
            take = chunk_limit_reg;
        end

        q_wr              = 1'b0;
        q_burst           = '0;
        payload_left_next = payload_left_reg;
        if (accept)
        begin
            unique case (cmd)
                chf_pkg::CMD_HEADER:
                begin
                    q_wr              = 1'b1;
                    q_burst.bytes     = hdr_bytes;
                    q_burst.len       = hdr_len;
                    q_burst.end_flag  = (take == '0);
                    payload_left_next = take;
                end
                chf_pkg::CMD_PAYLOAD:
                begin
                    // Bytes beyond the chunk budget are dropped.
                    if (payload_left_reg != '0)
                    begin
                        q_wr              = 1'b1;
                        q_burst.bytes[0]  = data_byte;
                        q_burst.len       = chf_pkg::LEN_W'(1);
                        q_burst.end_flag  = (payload_left_reg == chf_pkg::CHUNK_LIMIT_W'(1));
                        payload_left_next = payload_left_reg - chf_pkg::CHUNK_LIMIT_W'(1);
                    end
                end
                default:
                begin
                    q_wr = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_limit_reg  <= chf_pkg::CHUNK_LIMIT_RESET;
            payload_left_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                chunk_limit_reg <= cfg_data;
            end
            payload_left_reg <= payload_left_next;
        end
    end

endmodule

// ===== design/chf_back.sv =====
// ----------------------------------------------------------------------------
// chf_back: byte sequencer
// Walks the head burst one byte per cycle into the output register when free.
// ----------------------------------------------------------------------------
module chf_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  chf_pkg::burst_t             q_burst,
    input  logic                        q_empty,
    output logic                        q_rd,
    output logic                        empty,
    input  logic                        pop,
    output logic [chf_pkg::BYTE_W-1:0]  out_byte,
    output logic                        chunk_end
);

    logic                        out_valid_reg;
    logic [chf_pkg::BYTE_W-1:0]  out_byte_reg;
    logic                        chunk_end_reg;
    logic [chf_pkg::IDX_W-1:0]   idx_reg;
    logic                        slot_free;
    logic                        load;
    logic                        last_byte;

    assign empty     = !out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign chunk_end = chunk_end_reg;

    assign slot_free = !out_valid_reg || pop;
    assign load      = slot_free && !q_empty;
    assign last_byte = ((chf_pkg::LEN_W'(idx_reg) + chf_pkg::LEN_W'(1)) == q_burst.len);
    assign q_rd      = load && last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (slot_free)
            begin
                out_valid_reg <= !q_empty;
            end
            if (load)
            begin
                idx_reg <= last_byte ? '0 : idx_reg + chf_pkg::IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg  <= q_burst.bytes[idx_reg];
            chunk_end_reg <= last_byte && q_burst.end_flag;
        end
    end

endmodule

// ===== design/chunk_header_framer.sv =====
// With the queue empty, the first byte of an item passes a queue slot and then the output
// register on its way to the result ports. One input transfer per cycle while the queue has
// room; one output byte per cycle while bytes are waiting and pop is high.
// A header item is a burst of 12 to 18 bytes; a payload item is a single byte.
// Reset (rst_n low, asynchronous) empties the queue and output register, sets the chunk
// limit to 128 and clears the payload budget, so payload before any header is dropped.
// ----------------------------------------------------------------------------
// chunk_header_framer: first-chunk framer for a message byte stream
// A front stage turns each kept item into a burst of bytes, a four-entry queue decouples
// it from a back stage that sends one byte per cycle while bytes wait and pop is high.
// ----------------------------------------------------------------------------
module chunk_header_framer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [chf_pkg::CHUNK_LIMIT_W-1:0]    cfg_data,
    input  logic                                 push,
    output logic                                 full,
    input  logic [chf_pkg::CMD_W-1:0]            cmd,
    input  logic [chf_pkg::CSID_W-1:0]           chunk_stream,
    input  logic [chf_pkg::FMT_W-1:0]            header_format,
    input  logic [chf_pkg::TS_W-1:0]             time_stamp,
    input  logic [chf_pkg::MLEN_W-1:0]           message_length,
    input  logic [chf_pkg::MTYPE_W-1:0]          message_type,
    input  logic [chf_pkg::SID_W-1:0]            stream_ident,
    input  logic [chf_pkg::PCOUNT_W-1:0]         payload_count,
    input  logic [chf_pkg::BYTE_W-1:0]           data_byte,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [chf_pkg::BYTE_W-1:0]           out_byte,
    output logic                                 chunk_end
);

    // Bursts between the front and back stages. The front writes one burst
    // per accepted item (or none for a dropped payload byte); the back reads
    // the head burst and retires it after its last byte has been loaded.
    chf_pkg::burst_t  wr_burst;
    chf_pkg::burst_t  rd_burst;
    logic             q_wr;
    logic             q_rd;
    logic             q_full;
    logic             q_empty;

    // The front stage holds the chunk limit and the remaining payload budget.
    // Because the budget is updated at transfer time, the queue only ever
    // carries bytes that will really go out, in their final order.
    chf_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .cmd            (cmd),
        .chunk_stream   (chunk_stream),
        .header_format  (header_format),
        .time_stamp     (time_stamp),
        .message_length (message_length),
        .message_type   (message_type),
        .stream_ident   (stream_ident),
        .payload_count  (payload_count),
        .data_byte      (data_byte),
        .q_full         (q_full),
        .q_wr           (q_wr),
        .q_burst        (wr_burst)
    );

    chf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_wr),
        .wr_burst (wr_burst),
        .rd_en    (q_rd),
        .rd_burst (rd_burst),
        .q_full   (q_full),
        .q_empty  (q_empty)
    );

    // The back stage refills its output register from the queue whenever it is empty or its
    // byte is being taken, so queued bytes stream out at one byte per cycle while pop stays high.
    chf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_burst   (rd_burst),
        .q_empty   (q_empty),
        .q_rd      (q_rd),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .chunk_end (chunk_end)
    );

endmodule

// ===== sim/chunk_header_framer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_header_framer_tb: self-checking bench for the chunk header framer
// Drives header and payload items through the push side and checks every
// popped byte against a byte-level prediction of the first chunk.
// ----------------------------------------------------------------------------

// One input item, with the same fields as the ports of the block.
typedef struct packed {
    logic [chf_pkg::CMD_W-1:0]      cmd;
    logic [chf_pkg::CSID_W-1:0]     chunk_stream;
    logic [chf_pkg::FMT_W-1:0]      header_format;
    logic [chf_pkg::TS_W-1:0]       time_stamp;
    logic [chf_pkg::MLEN_W-1:0]     message_length;
    logic [chf_pkg::MTYPE_W-1:0]    message_type;
    logic [chf_pkg::SID_W-1:0]      stream_ident;
    logic [chf_pkg::PCOUNT_W-1:0]   payload_count;
    logic [chf_pkg::BYTE_W-1:0]     data_byte;
} framer_item_t;

// Predicts the framed byte stream and checks each popped byte against it.
class framed_byte_tracker;
    typedef struct packed {
        logic [chf_pkg::BYTE_W-1:0] value;
        logic                       last;
    } wire_byte_t;

    wire_byte_t                        wire_bytes_due[$];
    logic [chf_pkg::CHUNK_LIMIT_W-1:0] chunk_limit;
    logic [chf_pkg::PCOUNT_W-1:0]      payload_left;
    logic [chf_pkg::PCOUNT_W-1:0]      payload_seen;
    int                                errors;

    function new();
        chunk_limit  = chf_pkg::CHUNK_LIMIT_RESET;
        payload_left = '0;
        payload_seen = '0;
        errors       = 0;
    endfunction

    function void set_chunk_limit(logic [chf_pkg::CHUNK_LIMIT_W-1:0] value);
        chunk_limit = value;
    endfunction

    function int pending();
        return wire_bytes_due.size();
    endfunction

    // Records an accepted item and returns how many bytes it will produce.
    function int note_item(framer_item_t it);
        logic [chf_pkg::BYTE_W-1:0]   burst[$];
        logic [chf_pkg::CSID_W-1:0]   offset;
        logic [23:0]                  ts24;
        logic [chf_pkg::PCOUNT_W-1:0] take;
        wire_byte_t                   entry;
        if (it.cmd == chf_pkg::CMD_HEADER)
        begin
            offset = it.chunk_stream - chf_pkg::ONE_BYTE_LIMIT;
            if (it.chunk_stream < chf_pkg::ONE_BYTE_LIMIT)
            begin
                burst.push_back({it.header_format, it.chunk_stream[5:0]});
            end
            else if (it.chunk_stream < chf_pkg::TWO_BYTE_LIMIT)
            begin
                burst.push_back({it.header_format, 6'd0});
                burst.push_back(offset[7:0]);
            end
            else
            begin
                // Three-byte form: the id offset goes out low byte first.
                burst.push_back({it.header_format, 6'd1});
                burst.push_back(offset[7:0]);
                burst.push_back(offset[15:8]);
            end
            ts24 = (it.time_stamp >= chf_pkg::TS_SAT) ? 24'hFF_FFFF : it.time_stamp[23:0];
            burst.push_back(ts24[23:16]);
            burst.push_back(ts24[15:8]);
            burst.push_back(ts24[7:0]);
            burst.push_back(it.message_length[23:16]);
            burst.push_back(it.message_length[15:8]);
            burst.push_back(it.message_length[7:0]);
            burst.push_back(it.message_type);
            burst.push_back(it.stream_ident[7:0]);
            burst.push_back(it.stream_ident[15:8]);
            burst.push_back(it.stream_ident[23:16]);
            burst.push_back(it.stream_ident[31:24]);
            if (it.time_stamp >= chf_pkg::TS_SAT)
            begin
                burst.push_back(it.time_stamp[31:24]);
                burst.push_back(it.time_stamp[23:16]);
                burst.push_back(it.time_stamp[15:8]);
                burst.push_back(it.time_stamp[7:0]);
            end
            take = (it.payload_count < chf_pkg::PCOUNT_W'(chunk_limit))
                 ? it.payload_count : chf_pkg::PCOUNT_W'(chunk_limit);
            payload_left = take;
            payload_seen = '0;
            // With no payload allowed, the header itself closes the chunk.
            foreach (burst[i])
            begin
                entry.value = burst[i];
                entry.last  = (i == burst.size() - 1) && (take == '0);
                wire_bytes_due.push_back(entry);
            end
            return burst.size();
        end
        if (payload_left == '0)
        begin
            return 0;
        end
        payload_left = payload_left - 1'b1;
        payload_seen = payload_seen + 1'b1;
        entry.value  = it.data_byte;
        entry.last   = (payload_left == '0);
        wire_bytes_due.push_back(entry);
        return 1;
    endfunction

    function void check_byte(logic [chf_pkg::BYTE_W-1:0] value, logic last);
        wire_byte_t want;
        if (wire_bytes_due.size() == 0)
        begin
            $display("%0t: unexpected byte, expected none, actual %02h chunk_end %0b",
                     $time, value, last);
            errors++;
            return;
        end
        want = wire_bytes_due.pop_front();
        if (value !== want.value)
        begin
            $display("%0t: out_byte expected %02h actual %02h", $time, want.value, value);
            errors++;
        end
        if (last !== want.last)
        begin
            $display("%0t: chunk_end expected %0b actual %0b", $time, want.last, last);
            errors++;
        end
    endfunction
endclass

module chunk_header_framer_tb;

    // The block drains one byte per cycle while pop is high; the settle wait
    // covers any item still inside after the last byte has left.
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_GOAL    = 45;
    localparam int FEED_CAP      = 30;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [chf_pkg::CHUNK_LIMIT_W-1:0] cfg_data;
    logic                              push;
    logic                              full;
    logic [chf_pkg::CMD_W-1:0]         cmd;
    logic [chf_pkg::CSID_W-1:0]        chunk_stream;
    logic [chf_pkg::FMT_W-1:0]         header_format;
    logic [chf_pkg::TS_W-1:0]          time_stamp;
    logic [chf_pkg::MLEN_W-1:0]        message_length;
    logic [chf_pkg::MTYPE_W-1:0]       message_type;
    logic [chf_pkg::SID_W-1:0]         stream_ident;
    logic [chf_pkg::PCOUNT_W-1:0]      payload_count;
    logic [chf_pkg::BYTE_W-1:0]        data_byte;
    logic                              empty;
    logic                              pop;
    logic [chf_pkg::BYTE_W-1:0]        out_byte;
    logic                              chunk_end;

    framed_byte_tracker tracker = new();

    // Idle odds in percent for each side, and a long receiver hold-off that
    // the receiver process counts down on its own.
    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int hold_off_cycles = 0;
    int framing_items   = 0;

    chunk_header_framer u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .cmd            (cmd),
        .chunk_stream   (chunk_stream),
        .header_format  (header_format),
        .time_stamp     (time_stamp),
        .message_length (message_length),
        .message_type   (message_type),
        .stream_ident   (stream_ident),
        .payload_count  (payload_count),
        .data_byte      (data_byte),
        .empty          (empty),
        .pop            (pop),
        .out_byte       (out_byte),
        .chunk_end      (chunk_end)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // A generous cap on the whole run.
    initial
    begin
        #10_000_000;
        $display("[chunk_header_framer] ERROR");
        $finish;
    end

    // Receiver side. A transfer happens at an edge where pop was high and
    // empty was low; the next pop decision is made right after that edge.
    initial
    begin
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                tracker.check_byte(out_byte, chunk_end);
            end
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    function automatic framer_item_t make_header(
        input logic [chf_pkg::CSID_W-1:0]   csid,
        input logic [chf_pkg::FMT_W-1:0]    fmt,
        input logic [chf_pkg::TS_W-1:0]     ts,
        input logic [chf_pkg::MLEN_W-1:0]   mlen,
        input logic [chf_pkg::MTYPE_W-1:0]  mtype,
        input logic [chf_pkg::SID_W-1:0]    sid,
        input logic [chf_pkg::PCOUNT_W-1:0] pcount
    );
        framer_item_t it;
        it.cmd            = chf_pkg::CMD_HEADER;
        it.chunk_stream   = csid;
        it.header_format  = fmt;
        it.time_stamp     = ts;
        it.message_length = mlen;
        it.message_type   = mtype;
        it.stream_ident   = sid;
        it.payload_count  = pcount;
        it.data_byte      = chf_pkg::BYTE_W'($urandom);
        return it;
    endfunction

    // Random header; the timestamp and chunk stream id are steered at the
    // boundaries that change the byte layout.
    function automatic framer_item_t random_header();
        logic [chf_pkg::CSID_W-1:0]   csid;
        logic [chf_pkg::TS_W-1:0]     ts;
        logic [chf_pkg::PCOUNT_W-1:0] pcount;
        case ($urandom_range(0, 3))
            0:       csid = chf_pkg::CSID_W'($urandom_range(0, 63));
            1:       csid = chf_pkg::CSID_W'($urandom_range(64, 319));
            2:       csid = chf_pkg::CSID_W'($urandom_range(320, 65599));
            default: csid = chf_pkg::CSID_W'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0:       ts = $urandom_range(0, 16'hFFFF);
            1:       ts = chf_pkg::TS_SAT - 1;
            2:       ts = chf_pkg::TS_SAT;
            3:       ts = chf_pkg::TS_SAT + 1;
            default: ts = $urandom;
        endcase
        case ($urandom_range(0, 15))
            0:       pcount = chf_pkg::PCOUNT_W'($urandom);
            1, 2:    pcount = chf_pkg::PCOUNT_W'($urandom_range(0, 300));
            default: pcount = chf_pkg::PCOUNT_W'($urandom_range(0, 12));
        endcase
        return make_header(csid, chf_pkg::FMT_W'($urandom), ts, chf_pkg::MLEN_W'($urandom),
                           chf_pkg::MTYPE_W'($urandom), $urandom, pcount);
    endfunction

    // Payload items carry random junk in the header fields, which the block
    // must ignore.
    function automatic framer_item_t random_payload();
        framer_item_t it;
        it           = random_header();
        it.cmd       = chf_pkg::CMD_PAYLOAD;
        it.data_byte = chf_pkg::BYTE_W'($urandom);
        return it;
    endfunction

    function automatic framer_item_t make_payload(input logic [chf_pkg::BYTE_W-1:0] value);
        framer_item_t it;
        it           = random_payload();
        it.data_byte = value;
        return it;
    endfunction

    // Offers one item and returns once it has been transferred. Push stays
    // high afterwards so that back-to-back items need no gap.
    task automatic send_item(input framer_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push           <= 1'b1;
        cmd            <= it.cmd;
        chunk_stream   <= it.chunk_stream;
        header_format  <= it.header_format;
        time_stamp     <= it.time_stamp;
        message_length <= it.message_length;
        message_type   <= it.message_type;
        stream_ident   <= it.stream_ident;
        payload_count  <= it.payload_count;
        data_byte      <= it.data_byte;
        do
            @(posedge clk);
        while (full);
        if (tracker.note_item(it) > 0)
        begin
            framing_items++;
        end
    endtask

    // A header followed by payload bytes. Most messages deliver exactly the
    // allowed bytes; some overrun (the extra bytes are dropped) and some are
    // cut short by the next header.
    task automatic send_message();
        framer_item_t hdr;
        int           allowed;
        int           feed;
        int           pick;
        hdr     = random_header();
        allowed = (hdr.payload_count < chf_pkg::PCOUNT_W'(tracker.chunk_limit))
                ? int'(hdr.payload_count) : int'(tracker.chunk_limit);
        if (allowed > FEED_CAP)
        begin
            allowed = FEED_CAP;
        end
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            feed = allowed;
        end
        else if (pick < 85)
        begin
            feed = allowed + $urandom_range(1, 3);
        end
        else
        begin
            feed = $urandom_range(0, allowed);
        end
        send_item(hdr);
        repeat (feed)
        begin
            send_item(random_payload());
        end
    endtask

    // Lowers push, waits for every predicted byte to be popped and then
    // idles for SETTLE_CYCLES.
    task automatic drain();
        push <= 1'b0;
        while (tracker.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_chunk_limit(input logic [chf_pkg::CHUNK_LIMIT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        tracker.set_chunk_limit(value);
    endtask

    task automatic random_phase(input logic [chf_pkg::CHUNK_LIMIT_W-1:0] size,
                                input int send_pct, input int recv_pct);
        drain();
        write_chunk_limit(size);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        framing_items = 0;
        while (framing_items < PHASE_GOAL)
        begin
            send_message();
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_data       <= '0;
        push           <= 1'b0;
        cmd            <= chf_pkg::CMD_HEADER;
        chunk_stream   <= '0;
        header_format  <= '0;
        time_stamp     <= '0;
        message_length <= '0;
        message_type   <= '0;
        stream_ident   <= '0;
        payload_count  <= '0;
        data_byte      <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, first at the reset chunk size. Payload arriving
        // before any header must vanish.
        send_item(make_payload(8'hA5));
        // All-zero header with no payload: the last header byte ends the chunk.
        send_item(make_header(17'd0, 2'd0, 32'd0, 24'd0, 8'd0, 32'd0, 24'd0));
        // Largest one-byte id, one below saturation, then an overrun byte.
        send_item(make_header(17'd63, 2'd3, chf_pkg::TS_SAT - 1, 24'hFF_FFFF, 8'hFF,
                              32'hFFFF_FFFF, 24'd2));
        send_item(make_payload(8'h00));
        send_item(make_payload(8'hFF));
        send_item(make_payload(8'h5A));
        // Smallest two-byte id with the timestamp exactly at saturation.
        send_item(make_header(17'd64, 2'd1, chf_pkg::TS_SAT, 24'h12_3456, 8'h14,
                              32'h0102_0304, 24'd1));
        send_item(make_payload(8'h3C));
        // Largest two-byte id, full timestamp, then a new header mid-payload.
        send_item(make_header(17'd319, 2'd2, 32'hFFFF_FFFF, 24'd7, 8'h09,
                              32'h8000_0001, 24'd3));
        send_item(make_payload(8'h81));
        send_item(make_header(17'd320, 2'd0, 32'h0100_0000, 24'd1, 8'h08,
                              32'd1, 24'd0));
        send_item(make_header(17'd65599, 2'd3, 32'h00AB_CDEF, 24'h80_0000, 8'h12,
                              32'hDEAD_BEEF, 24'd1));
        send_item(make_payload(8'h7E));
        // Ids past the three-byte range wrap to their low 16 bits of offset.
        send_item(make_header(17'd131071, 2'd1, 32'd5, 24'd0, 8'd1, 32'd2, 24'd0));
        send_item(make_header(17'd65600, 2'd2, 32'd6, 24'd0, 8'd1, 32'd3, 24'd200));

        // Chunk size zero lets no payload through.
        drain();
        write_chunk_limit('0);
        send_item(make_header(17'd2, 2'd0, 32'd10, 24'd5, 8'h14, 32'd0, 24'd5));
        send_item(make_payload(8'h11));
        // A small chunk size clips the payload.
        drain();
        write_chunk_limit(17'd2);
        send_item(make_header(17'd100, 2'd1, 32'd20, 24'd5, 8'h09, 32'd4, 24'd5));
        send_item(make_payload(8'h22));
        send_item(make_payload(8'h33));
        send_item(make_payload(8'h44));

        // Random part. The first phase opens with a long receiver stall so
        // the queue fills and the block pushes back on the sender.
        drain();
        hold_off_cycles = 400;
        random_phase(17'd1, 32, 46);
        random_phase(17'd65536, 32, 46);
        random_phase(17'h1_FFFF, 46, 32);
        random_phase(17'd0, 46, 32);
        random_phase(17'd5, 0, 0);
        random_phase(chf_pkg::CHUNK_LIMIT_W'($urandom_range(2, 40)), 0, 0);
        drain();

        if (tracker.errors == 0 && tracker.pending() == 0)
        begin
            $display("[chunk_header_framer] OK");
        end
        else
        begin
            $display("[chunk_header_framer] ERROR");
        end
        $finish;
    end

endmodule

// ===== chunk_header_framer.f =====
design/chf_pkg.sv
design/chf_queue.sv
design/chf_front.sv
design/chf_back.sv
design/chunk_header_framer.sv
sim/chunk_header_framer_tb.sv
